// ===== sv/qslp_pkg.sv =====
`default_nettype none
package qslp_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 16;
    localparam int DIV_STEPS    = 32;

    localparam int VEC_W = 36;
    localparam int ANG_W = 34;

    localparam logic [15:0] ONE_Q15         = 16'd32768;
    localparam logic [15:0] THR_RESET       = 16'd32765;
    localparam logic [31:0] CORDIC_GAIN_INV = 32'd652032874;

    // pipeline positions, counted in register stages after the input transfer
    localparam int POS_V    = 4;
    localparam int POS_SQ   = POS_V + SQRT_STEPS;
    localparam int POS_OM   = POS_SQ + CORDIC_STEPS;
    localparam int POS_ANG  = POS_OM + 1;
    localparam int POS_SIN  = POS_ANG + CORDIC_STEPS;
    localparam int POS_K    = POS_SIN + DIV_STEPS;
    localparam int POS_PROD = POS_K + 1;
    localparam int POS_OUT  = POS_PROD + 1;

    typedef struct packed {
        logic signed [15:0] a_w;
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] b_w;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic [15:0]        fraction;
    } in_t;

    typedef struct packed {
        logic signed [15:0] out_w;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic               linear_used;
    } out_t;

    typedef struct packed {
        logic [3:0][15:0] a;
        logic [3:0][16:0] b;
        logic [15:0]      t;
        logic [15:0]      c;
        logic             lin;
    } side_t;

    // floor(atan(2^-i) * 2^30)
    function automatic logic [31:0] atan_val(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'd843314856;
            1:  r = 32'd497837829;
            2:  r = 32'd263043836;
            3:  r = 32'd133525158;
            4:  r = 32'd67021686;
            5:  r = 32'd33543515;
            6:  r = 32'd16775850;
            7:  r = 32'd8388437;
            8:  r = 32'd4194282;
            9:  r = 32'd2097149;
            10: r = 32'd1048575;
            11: r = 32'd524287;
            12: r = 32'd262143;
            13: r = 32'd131071;
            14: r = 32'd65535;
            15: r = 32'd32767;
            16: r = 32'd16383;
            17: r = 32'd8191;
            18: r = 32'd4095;
            19: r = 32'd2047;
            20: r = 32'd1023;
            21: r = 32'd511;
            22: r = 32'd255;
            23: r = 32'd127;
            24: r = 32'd63;
            25: r = 32'd31;
            26: r = 32'd15;
            27: r = 32'd7;
            28: r = 32'd3;
            29: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/qslp_isqrt.sv =====
`default_nettype none
module qslp_isqrt (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [30:0] val,
    output logic [15:0]      root
);

    logic [31:0] v_reg [qslp_pkg::SQRT_STEPS];
    logic [31:0] r_reg [qslp_pkg::SQRT_STEPS];

    for (genvar k = 0; k < qslp_pkg::SQRT_STEPS; k++)
    begin : g_step
        logic [31:0] v_in;
        logic [31:0] r_in;
        logic [31:0] bit_k;
        logic [31:0] trial;
        logic [31:0] v_next;
        logic [31:0] r_next;

        if (k == 0)
        begin : g_first
            assign v_in = {1'b0, val};
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign v_in = v_reg[k-1];
            assign r_in = r_reg[k-1];
        end

        assign bit_k = 32'd1 << (30 - 2 * k);
        assign trial = r_in + bit_k;

        always_comb
        begin
            if (v_in >= trial)
            begin
                v_next = v_in - trial;
                r_next = (r_in >> 1) + bit_k;
            end
            else
            begin
                v_next = v_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k] <= v_next;
                r_reg[k] <= r_next;
            end
        end
    end

    assign root = r_reg[qslp_pkg::SQRT_STEPS-1][15:0];

endmodule
`default_nettype wire

// ===== sv/qslp_cordic_vec.sv =====
`default_nettype none
module qslp_cordic_vec (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [qslp_pkg::VEC_W-1:0] x_in,
    input  wire logic signed [qslp_pkg::VEC_W-1:0] y_in,
    output logic signed [qslp_pkg::ANG_W-1:0]      angle
);

    logic signed [qslp_pkg::VEC_W-1:0] x_reg [qslp_pkg::CORDIC_STEPS];
    logic signed [qslp_pkg::VEC_W-1:0] y_reg [qslp_pkg::CORDIC_STEPS];
    logic signed [qslp_pkg::ANG_W-1:0] z_reg [qslp_pkg::CORDIC_STEPS];

    for (genvar k = 0; k < qslp_pkg::CORDIC_STEPS; k++)
    begin : g_step
        logic signed [qslp_pkg::VEC_W-1:0] x_in_k;
        logic signed [qslp_pkg::VEC_W-1:0] y_in_k;
        logic signed [qslp_pkg::ANG_W-1:0] z_in_k;
        logic signed [qslp_pkg::ANG_W-1:0] at;
        logic signed [qslp_pkg::VEC_W-1:0] x_next;
        logic signed [qslp_pkg::VEC_W-1:0] y_next;
        logic signed [qslp_pkg::ANG_W-1:0] z_next;

        if (k == 0)
        begin : g_first
            assign x_in_k = x_in;
            assign y_in_k = y_in;
            assign z_in_k = '0;
        end
        else
        begin : g_rest
            assign x_in_k = x_reg[k-1];
            assign y_in_k = y_reg[k-1];
            assign z_in_k = z_reg[k-1];
        end

        assign at = $signed({2'b00, qslp_pkg::atan_val(k)});

        always_comb
        begin
            if (!y_in_k[qslp_pkg::VEC_W-1])
            begin
                x_next = x_in_k + (y_in_k >>> k);
                y_next = y_in_k - (x_in_k >>> k);
                z_next = z_in_k + at;
            end
            else
            begin
                x_next = x_in_k - (y_in_k >>> k);
                y_next = y_in_k + (x_in_k >>> k);
                z_next = z_in_k - at;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k] <= x_next;
                y_reg[k] <= y_next;
                z_reg[k] <= z_next;
            end
        end
    end

    assign angle = z_reg[qslp_pkg::CORDIC_STEPS-1];

endmodule
`default_nettype wire

// ===== sv/qslp_cordic_rot.sv =====
`default_nettype none
module qslp_cordic_rot (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [qslp_pkg::ANG_W-1:0] angle,
    output logic signed [qslp_pkg::VEC_W-1:0]      sine
);

    logic signed [qslp_pkg::VEC_W-1:0] x_reg [qslp_pkg::CORDIC_STEPS];
    logic signed [qslp_pkg::VEC_W-1:0] y_reg [qslp_pkg::CORDIC_STEPS];
    logic signed [qslp_pkg::ANG_W-1:0] z_reg [qslp_pkg::CORDIC_STEPS];

    for (genvar k = 0; k < qslp_pkg::CORDIC_STEPS; k++)
    begin : g_step
        logic signed [qslp_pkg::VEC_W-1:0] x_in_k;
        logic signed [qslp_pkg::VEC_W-1:0] y_in_k;
        logic signed [qslp_pkg::ANG_W-1:0] z_in_k;
        logic signed [qslp_pkg::ANG_W-1:0] at;
        logic signed [qslp_pkg::VEC_W-1:0] x_next;
        logic signed [qslp_pkg::VEC_W-1:0] y_next;
        logic signed [qslp_pkg::ANG_W-1:0] z_next;

        if (k == 0)
        begin : g_first
            assign x_in_k = $signed({{(qslp_pkg::VEC_W-32){1'b0}},
                                     qslp_pkg::CORDIC_GAIN_INV});
            assign y_in_k = '0;
            assign z_in_k = angle;
        end
        else
        begin : g_rest
            assign x_in_k = x_reg[k-1];
            assign y_in_k = y_reg[k-1];
            assign z_in_k = z_reg[k-1];
        end

        assign at = $signed({2'b00, qslp_pkg::atan_val(k)});

        always_comb
        begin
            if (!z_in_k[qslp_pkg::ANG_W-1])
            begin
                x_next = x_in_k - (y_in_k >>> k);
                y_next = y_in_k + (x_in_k >>> k);
                z_next = z_in_k - at;
            end
            else
            begin
                x_next = x_in_k + (y_in_k >>> k);
                y_next = y_in_k - (x_in_k >>> k);
                z_next = z_in_k + at;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k] <= x_next;
                y_reg[k] <= y_next;
                z_reg[k] <= z_next;
            end
        end
    end

    assign sine = y_reg[qslp_pkg::CORDIC_STEPS-1];

endmodule
`default_nettype wire

// ===== sv/qslp_div.sv =====
`default_nettype none
module qslp_div (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] dividend,
    input  wire logic [15:0] divisor,
    output logic [15:0]      weight
);

    logic [15:0] rem_reg [qslp_pkg::DIV_STEPS];
    logic [31:0] q_reg   [qslp_pkg::DIV_STEPS];
    logic [15:0] d_reg   [qslp_pkg::DIV_STEPS];
    logic [31:0] q_last;

    for (genvar k = 0; k < qslp_pkg::DIV_STEPS; k++)
    begin : g_step
        logic [15:0] rem_in;
        logic [31:0] q_in;
        logic [15:0] d_in;
        logic [16:0] shifted;
        logic        fits;
        logic [15:0] rem_next;
        logic [31:0] q_next;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign q_in   = dividend;
            assign d_in   = divisor;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign d_in   = d_reg[k-1];
        end

        assign shifted  = {rem_in, q_in[31]};
        assign fits     = shifted >= {1'b0, d_in};
        assign rem_next = fits ? 16'(shifted - {1'b0, d_in}) : shifted[15:0];
        assign q_next   = {q_in[30:0], fits};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                q_reg[k]   <= q_next;
                d_reg[k]   <= d_in;
            end
        end
    end

    assign q_last = q_reg[qslp_pkg::DIV_STEPS-1];
    assign weight = (q_last > {16'd0, qslp_pkg::ONE_Q15}) ? qslp_pkg::ONE_Q15 : q_last[15:0];

endmodule
`default_nettype wire

// ===== sv/quaternion_slerp_core.sv =====
// throughput: one item per cycle; the whole pipeline holds while a result is stalled
// latency is set by the 16-step square root, two 16-step cordic passes
// and the 32-step weight divider, each one step per register stage
// reset clears every stage valid bit and sets the threshold register thr_reg to 32765
`default_nettype none
module quaternion_slerp_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire qslp_pkg::in_t   in_data,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output qslp_pkg::out_t       out_data,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [15:0]     cfg_data
);

    logic                      en;
    logic [15:0]               thr_reg;
    logic [qslp_pkg::POS_OUT:1] vld_reg;

    qslp_pkg::in_t             in1_reg;
    qslp_pkg::in_t             in2_reg;
    logic signed [31:0]        prod1_reg [4];
    logic signed [33:0]        dot_reg;
    logic [30:0]               v_reg;

    qslp_pkg::side_t           side_reg [qslp_pkg::POS_V-1:qslp_pkg::POS_K];
    qslp_pkg::side_t           side3_next;
    logic [15:0]               s_reg [qslp_pkg::POS_SQ+1:qslp_pkg::POS_K];

    logic [15:0]               root;
    logic signed [qslp_pkg::VEC_W-1:0] vx0;
    logic signed [qslp_pkg::VEC_W-1:0] vy0;
    logic signed [qslp_pkg::ANG_W-1:0] omega;
    logic [31:0]               om_pos;
    logic [15:0]               t_om;
    logic [15:0]               tc_om;
    logic [47:0]               ang1_prod;
    logic [47:0]               ang0_prod;
    logic signed [qslp_pkg::ANG_W-1:0] ang0_reg;
    logic signed [qslp_pkg::ANG_W-1:0] ang1_reg;
    logic signed [qslp_pkg::VEC_W-1:0] sin0;
    logic signed [qslp_pkg::VEC_W-1:0] sin1;
    logic [31:0]               div0_in;
    logic [31:0]               div1_in;
    logic [15:0]               k0_div;
    logic [15:0]               k1_div;

    logic                      lin_k;
    logic signed [16:0]        k0_sel;
    logic signed [16:0]        k1_sel;
    logic signed [32:0]        pa_reg [4];
    logic signed [33:0]        pb_reg [4];
    logic                      lin_p_reg;
    qslp_pkg::out_t            out_next;
    qslp_pkg::out_t            out_reg;

    logic signed [15:0]        a_in [4];
    logic signed [15:0]        b_in [4];
    logic signed [15:0]        a2 [4];
    logic signed [15:0]        b2 [4];
    logic                      neg;
    logic [33:0]               dabs;
    logic [18:0]               rnd;
    logic [15:0]               c3;
    logic [15:0]               t3;

    assign en        = !vld_reg[qslp_pkg::POS_OUT] || !out_stall;
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;
    assign out_valid = vld_reg[qslp_pkg::POS_OUT];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= qslp_pkg::THR_RESET;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
            if (en)
            begin
                vld_reg <= {vld_reg[qslp_pkg::POS_OUT-1:1], in_valid};
            end
        end
    end

    // dot product lanes
    always_comb
    begin
        a_in[0] = in_data.a_w;
        a_in[1] = in_data.a_x;
        a_in[2] = in_data.a_y;
        a_in[3] = in_data.a_z;
        b_in[0] = in_data.b_w;
        b_in[1] = in_data.b_x;
        b_in[2] = in_data.b_y;
        b_in[3] = in_data.b_z;
        a2[0]   = in2_reg.a_w;
        a2[1]   = in2_reg.a_x;
        a2[2]   = in2_reg.a_y;
        a2[3]   = in2_reg.a_z;
        b2[0]   = in2_reg.b_w;
        b2[1]   = in2_reg.b_x;
        b2[2]   = in2_reg.b_y;
        b2[3]   = in2_reg.b_z;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in1_reg <= in_data;
            for (int i = 0; i < 4; i++)
            begin
                prod1_reg[i] <= a_in[i] * b_in[i];
            end
            in2_reg <= in1_reg;
            dot_reg <= 34'(prod1_reg[0]) + 34'(prod1_reg[1])
                     + 34'(prod1_reg[2]) + 34'(prod1_reg[3]);
        end
    end

    // shorter arc, cosine and threshold
    always_comb
    begin
        neg  = dot_reg[33];
        dabs = neg ? 34'(-dot_reg) : 34'(dot_reg);
        rnd  = 19'((dabs + 34'd16384) >> 15);
        c3   = (rnd > 19'(qslp_pkg::ONE_Q15)) ? qslp_pkg::ONE_Q15 : rnd[15:0];
        t3   = (in2_reg.fraction > qslp_pkg::ONE_Q15) ? qslp_pkg::ONE_Q15
                                                      : in2_reg.fraction;
        for (int i = 0; i < 4; i++)
        begin
            side3_next.a[i] = a2[i];
            side3_next.b[i] = neg ? 17'(-17'(b2[i])) : 17'(b2[i]);
        end
        side3_next.t   = t3;
        side3_next.c   = c3;
        side3_next.lin = c3 > thr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[qslp_pkg::POS_V-1] <= side3_next;
            v_reg <= 31'(32'h4000_0000 - (side_reg[qslp_pkg::POS_V-1].c
                                         * side_reg[qslp_pkg::POS_V-1].c));
        end
    end

    for (genvar p = qslp_pkg::POS_V; p <= qslp_pkg::POS_K; p++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[p] <= side_reg[p-1];
            end
        end
    end

    qslp_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .val  (v_reg),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg[qslp_pkg::POS_SQ+1] <= root;
        end
    end

    for (genvar p = qslp_pkg::POS_SQ + 2; p <= qslp_pkg::POS_K; p++)
    begin : g_sine_base
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[p] <= s_reg[p-1];
            end
        end
    end

    assign vx0 = $signed({{(qslp_pkg::VEC_W-31){1'b0}},
                          side_reg[qslp_pkg::POS_SQ].c, 15'd0});
    assign vy0 = $signed({{(qslp_pkg::VEC_W-31){1'b0}}, root, 15'd0});

    qslp_cordic_vec u_vec (
        .clk   (clk),
        .en    (en),
        .x_in  (vx0),
        .y_in  (vy0),
        .angle (omega)
    );

    // scaled angles
    assign om_pos    = omega[qslp_pkg::ANG_W-1] ? 32'd0 : omega[31:0];
    assign t_om      = side_reg[qslp_pkg::POS_OM].t;
    assign tc_om     = 16'(qslp_pkg::ONE_Q15 - t_om);
    assign ang1_prod = {32'd0, t_om} * {16'd0, om_pos};
    assign ang0_prod = {32'd0, tc_om} * {16'd0, om_pos};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang1_reg <= $signed({2'b00, ang1_prod[46:15]});
            ang0_reg <= $signed({2'b00, ang0_prod[46:15]});
        end
    end

    qslp_cordic_rot u_rot0 (
        .clk   (clk),
        .en    (en),
        .angle (ang0_reg),
        .sine  (sin0)
    );

    qslp_cordic_rot u_rot1 (
        .clk   (clk),
        .en    (en),
        .angle (ang1_reg),
        .sine  (sin1)
    );

    assign div0_in = sin0[qslp_pkg::VEC_W-1] ? 32'd0 : sin0[31:0];
    assign div1_in = sin1[qslp_pkg::VEC_W-1] ? 32'd0 : sin1[31:0];

    qslp_div u_div0 (
        .clk      (clk),
        .en       (en),
        .dividend (div0_in),
        .divisor  (s_reg[qslp_pkg::POS_SIN]),
        .weight   (k0_div)
    );

    qslp_div u_div1 (
        .clk      (clk),
        .en       (en),
        .dividend (div1_in),
        .divisor  (s_reg[qslp_pkg::POS_SIN]),
        .weight   (k1_div)
    );

    // weight select and blend products
    assign lin_k  = side_reg[qslp_pkg::POS_K].lin || (s_reg[qslp_pkg::POS_K] == 16'd0);
    assign k0_sel = lin_k ? $signed({1'b0, 16'(qslp_pkg::ONE_Q15 - side_reg[qslp_pkg::POS_K].t)})
                          : $signed({1'b0, k0_div});
    assign k1_sel = lin_k ? $signed({1'b0, side_reg[qslp_pkg::POS_K].t})
                          : $signed({1'b0, k1_div});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pa_reg[i] <= $signed(side_reg[qslp_pkg::POS_K].a[i]) * k0_sel;
                pb_reg[i] <= $signed(side_reg[qslp_pkg::POS_K].b[i]) * k1_sel;
            end
            lin_p_reg <= lin_k;
        end
    end

    // round and saturate
    always_comb
    begin
        logic signed [35:0] sum;
        logic signed [20:0] sh;
        logic signed [15:0] r [4];
        for (int i = 0; i < 4; i++)
        begin
            sum = 36'(pa_reg[i]) + 36'(pb_reg[i]) + 36'sd16384;
            sh  = 21'(sum >>> 15);
            if (sh > 21'sd32767)
            begin
                r[i] = 16'sh7fff;
            end
            else if (sh < -21'sd32768)
            begin
                r[i] = 16'sh8000;
            end
            else
            begin
                r[i] = sh[15:0];
            end
        end
        out_next.out_w       = r[0];
        out_next.out_x       = r[1];
        out_next.out_y       = r[2];
        out_next.out_z       = r[3];
        out_next.linear_used = lin_p_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire
